@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the radix digit converter RTL.
// Self-contained; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds -> b holds in the same cycle
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");

// a holds -> b holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/rdc_pkg.sv @@
// Package for the radix digit converter: sizes, radix limits, state codes,
// controller/datapath command and status types, digit-to-character function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

    localparam int VALUE_BITS = 31;
    localparam int MAX_DIGITS = 32;
    localparam int DIGIT_W    = 5;
    localparam int CHAR_W     = 7;
    localparam int PTR_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int BCNT_W     = $clog2(VALUE_BITS + 1);

    localparam logic [DIGIT_W-1:0] RADIX_MIN     = DIGIT_W'(2);
    localparam logic [DIGIT_W-1:0] RADIX_MAX     = DIGIT_W'(20);
    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  CHAR_A        = CHAR_W'(65);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic push;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic quo_zero;
        logic last;
        logic out_free;
    } t_status;

    function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL_LIMIT) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DECIMAL_LIMIT);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rdc_ctrl.sv @@
// Controller for the radix digit converter: sequences load, divide, push
// and emit. Depends on rdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire rdc_pkg::t_status i_sts,
    output rdc_pkg::t_cmd         o_cmd
);

    rdc_pkg::t_state r_state;
    rdc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rdc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = rdc_pkg::S_DIV;
                end
            end
            rdc_pkg::S_DIV: begin
                if (!i_sts.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    o_cmd.push = 1'b1;
                    if (i_sts.quo_zero) begin
                        n_state = rdc_pkg::S_READ;
                    end else begin
                        o_cmd.div_start = 1'b1;
                    end
                end
            end
            rdc_pkg::S_READ: begin
                n_state = rdc_pkg::S_EMIT;
            end
            rdc_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.last ? rdc_pkg::S_IDLE : rdc_pkg::S_READ;
                end
            end
            default: n_state = rdc_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/rdc_dpath.sv @@
// Datapath for the radix digit converter: radix register, bit-serial
// divider, digit stack memory and output register. Depends on rdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdc_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [rdc_pkg::DIGIT_W-1:0]   i_cfg_wr_data,
    input  wire logic [rdc_pkg::VALUE_BITS-1:0] i_value,
    input  wire rdc_pkg::t_cmd                 i_cmd,
    output rdc_pkg::t_status                   o_sts,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [rdc_pkg::DIGIT_W-1:0]        o_digit,
    output logic [rdc_pkg::CHAR_W-1:0]         o_char_code,
    output logic                               o_last
);

    logic [rdc_pkg::DIGIT_W-1:0]    r_radix;
    logic [rdc_pkg::VALUE_BITS-1:0] r_quo;
    logic [rdc_pkg::DIGIT_W-1:0]    r_rem;
    logic [rdc_pkg::BCNT_W-1:0]     r_bitcnt;
    logic [rdc_pkg::PTR_W-1:0]      r_wptr;
    logic [rdc_pkg::PTR_W-1:0]      r_rptr;
    logic [rdc_pkg::CNT_W-1:0]      r_cnt;
    logic [rdc_pkg::CNT_W-1:0]      r_left;
    logic [rdc_pkg::DIGIT_W-1:0]    r_rdata;
    logic [rdc_pkg::DIGIT_W-1:0]    r_stack [rdc_pkg::MAX_DIGITS];
    logic                           r_out_valid;
    logic [rdc_pkg::DIGIT_W-1:0]    r_digit;
    logic [rdc_pkg::CHAR_W-1:0]     r_char;
    logic                           r_last;

    logic [rdc_pkg::DIGIT_W:0]      trial;
    logic                           qbit;
    logic [rdc_pkg::DIGIT_W-1:0]    n_rem;
    logic [rdc_pkg::CNT_W-1:0]      n_cnt;
    logic [rdc_pkg::PTR_W-1:0]      n_wptr;
    logic [rdc_pkg::PTR_W-1:0]      n_rptr;

    always_comb begin
        trial = {r_rem, r_quo[rdc_pkg::VALUE_BITS-1]};
        qbit  = (trial >= {1'b0, r_radix});
        n_rem = qbit ? rdc_pkg::DIGIT_W'(trial - {1'b0, r_radix})
                     : rdc_pkg::DIGIT_W'(trial);
        n_cnt = (r_cnt == rdc_pkg::CNT_W'(rdc_pkg::MAX_DIGITS)) ? r_cnt
                                                                 : r_cnt + 1'b1;
        n_wptr = (r_wptr == rdc_pkg::PTR_W'(rdc_pkg::MAX_DIGITS - 1)) ? '0
                                                                        : r_wptr + 1'b1;
        n_rptr = (r_rptr == '0) ? rdc_pkg::PTR_W'(rdc_pkg::MAX_DIGITS - 1)
                                : r_rptr - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= rdc_pkg::RADIX_MIN;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_wr_data < rdc_pkg::RADIX_MIN) begin
                r_radix <= rdc_pkg::RADIX_MIN;
            end else if (i_cfg_wr_data > rdc_pkg::RADIX_MAX) begin
                r_radix <= rdc_pkg::RADIX_MAX;
            end else begin
                r_radix <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitcnt <= '0;
            r_wptr   <= '0;
            r_cnt    <= '0;
            r_quo    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_quo  <= i_value;
                r_wptr <= '0;
                r_cnt  <= '0;
            end else if (i_cmd.div_step) begin
                r_quo <= {r_quo[rdc_pkg::VALUE_BITS-2:0], qbit};
            end
            if (i_cmd.div_start) begin
                r_bitcnt <= rdc_pkg::BCNT_W'(rdc_pkg::VALUE_BITS);
            end else if (i_cmd.div_step) begin
                r_bitcnt <= r_bitcnt - 1'b1;
            end
            if (i_cmd.push) begin
                r_wptr <= n_wptr;
                r_cnt  <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
        end
        if (i_cmd.push) begin
            r_rptr <= r_wptr;
            r_left <= n_cnt;
        end else if (i_cmd.emit) begin
            r_rptr <= n_rptr;
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[r_wptr] <= r_rem;
        end
        r_rdata <= r_stack[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_digit <= r_rdata;
            r_char  <= rdc_pkg::char_of(r_rdata);
            r_last  <= (r_left == rdc_pkg::CNT_W'(1));
        end
    end

    assign o_sts.div_done = (r_bitcnt == '0);
    assign o_sts.quo_zero = (r_quo == '0);
    assign o_sts.last     = (r_left == rdc_pkg::CNT_W'(1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_digit     = r_digit;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

`default_nettype wire

@@ hw/rtl/radix_digit_converter.sv @@
// Radix digit converter top level: joins controller and datapath.
// Depends on rdc_pkg, rdc_ctrl, rdc_dpath and assert_macros.svh.
//
// Use:
//   Input request: i_in_valid / o_in_ready with i_value (31 bits, unsigned).
//   Output requests: o_out_valid / i_out_ready with o_digit, o_char_code and
//   o_last, one per digit, most significant digit first; o_last marks the
//   final digit. Zero gives the single digit 0.
//   Radix: write i_cfg_wr_data with i_cfg_wr_en high while idle; values
//   below 2 store 2, above 20 store 20.
// Conversion:
//   One shared restoring divider produces one quotient bit per cycle; each
//   digit takes 31 divider steps and then a push onto the digit stack.
//   The digit stack memory has a registered read, so each digit is emitted
//   through a read state and then an emit state. The next input request can
//   be taken in the cycle after the last output request is loaded.
// Reset (i_rst_n low, synchronous): controller idle, output empty, radix 2.
// Stall: a held output request freezes emission; the last digit may wait in
// the output register while the next input request is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module radix_digit_converter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [rdc_pkg::DIGIT_W-1:0]    i_cfg_wr_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [rdc_pkg::VALUE_BITS-1:0] i_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [rdc_pkg::DIGIT_W-1:0]         o_digit,
    output logic [rdc_pkg::CHAR_W-1:0]          o_char_code,
    output logic                                o_last
);

    rdc_pkg::t_cmd    cmd;
    rdc_pkg::t_status sts;

    rdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rdc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_digit       (o_digit),
        .o_char_code   (o_char_code),
        .o_last        (o_last)
    );

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_SAME(a_emit_into_free_slot, i_clk, i_rst_n, cmd.emit, sts.out_free)
    `ASSERT_NEXT(a_last_emit_idles, i_clk, i_rst_n, cmd.emit && sts.last, o_in_ready && o_last)
    `ASSERT_SAME(a_no_push_outside_div, i_clk, i_rst_n, cmd.push, !o_in_ready && !cmd.emit)

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for radix_digit_converter: directed table, then random values
// over several radices, digits compared with typed strings or a local base conversion.
// Depends on rdc_pkg and the radix_digit_converter RTL.
`timescale 1ns / 1ps

module tb;

    localparam int DIR_ROWS       = 23;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 48;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int STACK_DEPTH    = 32;
    localparam int CHR_ZERO       = 48;
    localparam int CHR_A          = 65;
    localparam int DEC_LIMIT      = 10;
    localparam int NO_WRITE       = -1;

    typedef struct packed {
        logic [rdc_pkg::DIGIT_W-1:0] digit;
        logic [rdc_pkg::CHAR_W-1:0]  char_code;
        logic                        last;
    } t_digit_rec;

    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_COMB,
        RX_SPARSE
    } t_rx_mode;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_wr_en = 1'b0;
    logic [rdc_pkg::DIGIT_W-1:0]    i_cfg_wr_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [rdc_pkg::VALUE_BITS-1:0] i_value = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [rdc_pkg::DIGIT_W-1:0]    o_digit;
    logic [rdc_pkg::CHAR_W-1:0]     o_char_code;
    logic                           o_last;

    t_digit_rec                  expected_digits [$];
    logic [rdc_pkg::DIGIT_W-1:0] cur_radix = rdc_pkg::RADIX_MIN;
    int                          burst_left = 0;
    int                          err_count = 0;
    int                          values_sent = 0;
    int                          digits_checked = 0;
    int                          radix_writes = 0;
    bit                          holdoff_armed = 1'b0;

    // Directed requests; an empty string leaves the digits to the predictor.
    int dir_cfg [DIR_ROWS] = '{
        NO_WRITE, NO_WRITE, NO_WRITE, NO_WRITE, NO_WRITE, 0, 1, 31, NO_WRITE, NO_WRITE,
        21, 10, NO_WRITE, NO_WRITE, 16, NO_WRITE, NO_WRITE, 3, NO_WRITE, 19,
        NO_WRITE, 11, 20
    };
    logic [rdc_pkg::VALUE_BITS-1:0] dir_value [DIR_ROWS] = '{
        31'd0, 31'd1, 31'd2, 31'h7FFF_FFFF, 31'h2AAA_AAAA, 31'd5, 31'd6, 31'd19, 31'd20,
        31'h7FFF_FFFF, 31'd0, 31'd2147483647, 31'd9, 31'd10, 31'h7FFF_FFFF, 31'd255,
        31'h1234_5678, 31'h7FFF_FFFF, 31'd2, 31'd18, 31'd361, 31'h5555_5555, 31'h4000_0000
    };
    string dir_want [DIR_ROWS] = '{
        "0", "1", "10", "1111111111111111111111111111111", "", "101", "110", "J", "10",
        "1DB1F927", "0", "2147483647", "9", "10", "7FFFFFFF", "FF",
        "12345678", "", "2", "I", "100", "", ""
    };

    radix_digit_converter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_digit       (o_digit),
        .o_char_code   (o_char_code),
        .o_last        (o_last)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [rdc_pkg::DIGIT_W-1:0] clamp_radix(
        input logic [rdc_pkg::DIGIT_W-1:0] w
    );
        if (w < rdc_pkg::RADIX_MIN) begin
            return rdc_pkg::RADIX_MIN;
        end
        if (w > rdc_pkg::RADIX_MAX) begin
            return rdc_pkg::RADIX_MAX;
        end
        return w;
    endfunction

    function automatic t_digit_rec make_digit(input logic [rdc_pkg::DIGIT_W-1:0] d,
                                              input logic fin);
        t_digit_rec r;
        r.digit = d;
        if (d < DEC_LIMIT) begin
            r.char_code = 7'(CHR_ZERO + int'(d));
        end else begin
            r.char_code = 7'(CHR_A + int'(d) - DEC_LIMIT);
        end
        r.last = fin;
        return r;
    endfunction

    task automatic expand_digits(input logic [rdc_pkg::VALUE_BITS-1:0] v,
                                 input logic [rdc_pkg::DIGIT_W-1:0] base);
        logic [rdc_pkg::DIGIT_W-1:0] stack [STACK_DEPTH];
        int unsigned q;
        int n;
        q = v;
        n = 0;
        do begin
            stack[n] = 5'(q % base);
            q = q / base;
            n++;
        end while (q != 0);
        for (int k = n - 1; k >= 0; k--) begin
            expected_digits.push_back(make_digit(stack[k], k == 0));
        end
    endtask

    task automatic push_typed(input string s);
        int c;
        int d;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            d = (c >= CHR_A) ? c - (CHR_A - DEC_LIMIT) : c - CHR_ZERO;
            expected_digits.push_back(make_digit(5'(d), i == s.len() - 1));
        end
    endtask

    function automatic logic [rdc_pkg::VALUE_BITS-1:0] pick_value(
        input logic [rdc_pkg::DIGIT_W-1:0] base
    );
        longint unsigned p;
        int k;
        logic [rdc_pkg::VALUE_BITS-1:0] v;
        case ($urandom_range(0, 5))
            0: v = 31'($urandom_range(0, base - 1));
            1: v = 31'($urandom_range(0, 1000));
            2: v = 31'($urandom);
            3: begin
                p = 1;
                k = $urandom_range(1, 31);
                repeat (k) begin
                    if (p * base <= 64'h7FFF_FFFF) begin
                        p = p * base;
                    end
                end
                v = 31'(p - $urandom_range(0, 1));
            end
            4: v = 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
            default: v = 31'($urandom >> $urandom_range(1, 31));
        endcase
        return v;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("tb: mismatch at %0t ns: %s", $realtime, what);
        err_count++;
    endtask

    task automatic wait_drained();
        while (expected_digits.size() != 0) @(posedge i_clk);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 5))
                0, 1: gap = 0;
                2:    gap = $urandom_range(30, 1200);
                default: gap = $urandom_range(1, 25);
            endcase
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic offer_value(input logic [rdc_pkg::VALUE_BITS-1:0] v, input string want);
        pace_sender();
        i_in_valid <= 1'b1;
        i_value    <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (want.len() == 0) begin
            expand_digits(v, cur_radix);
        end else begin
            push_typed(want);
        end
        values_sent++;
    endtask

    task automatic write_radix(input logic [rdc_pkg::DIGIT_W-1:0] w);
        i_in_valid <= 1'b0;
        burst_left = 0;
        wait_drained();
        while (!o_in_ready) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_radix = clamp_radix(w);
        radix_writes++;
    endtask

    initial begin : digit_sink
        t_rx_mode   mode;
        int         mode_left;
        int         hold_left;
        bit         hold_used;
        int         tick;
        logic       rdy;
        t_digit_rec want;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        hold_used = 1'b0;
        tick      = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (expected_digits.size() == 0) begin
                    flag_mismatch($sformatf("unexpected digit %0d", o_digit));
                end else begin
                    want = expected_digits.pop_front();
                    if (o_digit !== want.digit) begin
                        flag_mismatch($sformatf("digit %0d, want %0d", o_digit, want.digit));
                    end
                    if (o_char_code !== want.char_code) begin
                        flag_mismatch($sformatf("char_code %0d, want %0d",
                                                o_char_code, want.char_code));
                    end
                    if (o_last !== want.last) begin
                        flag_mismatch($sformatf("last %0b, want %0b", o_last, want.last));
                    end
                    digits_checked++;
                end
            end
            if (holdoff_armed && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLDOFF_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 200);
            end
            mode_left--;
            tick++;
            case (mode)
                RX_FREE:   rdy = 1'b1;
                RX_RANDOM: rdy = 1'($urandom_range(0, 1));
                RX_COMB:   rdy = (tick % 3) != 0;
                default:   rdy = (tick % 8) == 0;
            endcase
            // Hold off the output for a long stretch once
            if (hold_left > 0) begin
                rdy = 1'b0;
                hold_left--;
            end
            i_out_ready <= rdy;
        end
    end

    initial begin : stimulus
        logic [rdc_pkg::DIGIT_W-1:0] w;
        int fixed_cfg [4];
        fixed_cfg = '{2, 20, 0, 31};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_cfg[i] != NO_WRITE) begin
                write_radix(5'(dir_cfg[i]));
            end
            offer_value(dir_value[i], dir_want[i]);
        end
        for (int ph = 0; ph < PHASES; ph++) begin
            w = (ph < 4) ? 5'(fixed_cfg[ph]) : 5'($urandom_range(0, 31));
            write_radix(w);
            if (ph == 0) begin
                holdoff_armed = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Drop the request and wait for every digit midway through phase 3
                if (ph == 3 && n == PHASE_ITEMS / 2) begin
                    i_in_valid <= 1'b0;
                    burst_left = 0;
                    wait_drained();
                end
                offer_value(pick_value(cur_radix), "");
            end
        end
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("tb: %0d values converted under %0d radix writes, %0d digits compared",
                 values_sent, radix_writes, digits_checked);
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #60_000_000;
        $display("tb: timeout, %0d digits still awaited", expected_digits.size());
        $display("tb: done, errors");
        $finish;
    end

endmodule

@@ radix_digit_converter.f @@
+incdir+hw/rtl
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_ctrl.sv
hw/rtl/rdc_dpath.sv
hw/rtl/radix_digit_converter.sv
tb/tb.sv
